// ----- rtl/core/ptac_pkg.sv -----
// ----------------------------------------------------------------------------
// ptac_pkg
// Shared constants, types and the arctangent table of the tangent angle block.
// ----------------------------------------------------------------------------
`default_nettype none

package ptac_pkg;

    localparam int COORD_WIDTH_DEF   = 32;
    localparam int ANGLE_WIDTH_DEF   = 16;
    localparam int CORDIC_STAGES_DEF = 16;

    // Depth of the vector queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Differences are scaled so the vector sits near bit 60; gain and the
    // quarter-turn pre-rotation need two more bits and a sign.
    localparam int SCALE_TOP = 60;
    localparam int CORD_W    = 63;

    localparam int ATAN_LEN   = 24;
    localparam int ATAN_IDX_W = 5;

    localparam logic [31:0] Z_POS_QUARTER = 32'h4000_0000;
    localparam logic [31:0] Z_NEG_QUARTER = 32'hC000_0000;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_RUN,
        BK_DONE
    } t_back_state;

    // atan(2^-i) as a 32-bit fraction of a turn
    function automatic logic [31:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h2000_0000;
            5'd1:    v = 32'h12E4_051E;
            5'd2:    v = 32'h09FB_385B;
            5'd3:    v = 32'h0511_11D4;
            5'd4:    v = 32'h028B_0D43;
            5'd5:    v = 32'h0145_D7E1;
            5'd6:    v = 32'h00A2_F61E;
            5'd7:    v = 32'h0051_7C55;
            5'd8:    v = 32'h0028_BE53;
            5'd9:    v = 32'h0014_5F2F;
            5'd10:   v = 32'h000A_2F98;
            5'd11:   v = 32'h0005_17CC;
            5'd12:   v = 32'h0002_8BE6;
            5'd13:   v = 32'h0001_45F3;
            5'd14:   v = 32'h0000_A2FA;
            5'd15:   v = 32'h0000_517D;
            5'd16:   v = 32'h0000_28BE;
            5'd17:   v = 32'h0000_145F;
            5'd18:   v = 32'h0000_0A30;
            5'd19:   v = 32'h0000_0518;
            5'd20:   v = 32'h0000_028C;
            5'd21:   v = 32'h0000_0146;
            5'd22:   v = 32'h0000_00A3;
            5'd23:   v = 32'h0000_0051;
            default: v = 32'h0000_0000;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ptac_if.sv -----
// ----------------------------------------------------------------------------
// ptac_if
// Valid/ready stream interfaces for points in and tangent angles out.
// ----------------------------------------------------------------------------
`default_nettype none

interface ptac_point_if #(
    parameter int COORD_WIDTH = ptac_pkg::COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] x_coord;
    logic signed [COORD_WIDTH-1:0] y_coord;
    logic                          last_point;

    modport source (output valid, output x_coord, output y_coord, output last_point,
                    input ready);
    modport sink   (input valid, input x_coord, input y_coord, input last_point,
                    output ready);
endinterface

interface ptac_angle_if #(
    parameter int ANGLE_WIDTH = ptac_pkg::ANGLE_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [ANGLE_WIDTH-1:0] angle;
    logic                          last_angle;

    modport source (output valid, output angle, output last_angle, input ready);
    modport sink   (input valid, input angle, input last_angle, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/ptac_front.sv -----
// ----------------------------------------------------------------------------
// ptac_front
// Point window: forms forward, central and backward difference vectors.
// ----------------------------------------------------------------------------
`default_nettype none

module ptac_front #(
    parameter int COORD_WIDTH = ptac_pkg::COORD_WIDTH_DEF,
    localparam int DIFF_W     = COORD_WIDTH + 1,
    localparam int VEC_W      = 2 * DIFF_W + 1
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_pt_valid,
    output logic                               o_pt_ready,
    input  wire logic signed [COORD_WIDTH-1:0] i_pt_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_pt_y,
    input  wire logic                          i_pt_last,
    output logic                               o_vec_valid,
    input  wire logic                          i_vec_ready,
    output logic [VEC_W-1:0]                   o_vec_data
);

    logic signed [COORD_WIDTH-1:0] r_older_x, r_older_y, r_newer_x, r_newer_y;
    logic [1:0]                    r_points_seen;
    logic                          r_pend;
    logic signed [DIFF_W-1:0]      r_pend_dx, r_pend_dy;

    logic                     accept;
    logic signed [DIFF_W-1:0] back_dx, back_dy, cent_dx, cent_dy;
    logic signed [DIFF_W-1:0] first_dx, first_dy;

    assign back_dx = {i_pt_x[COORD_WIDTH-1], i_pt_x} - {r_newer_x[COORD_WIDTH-1], r_newer_x};
    assign back_dy = {i_pt_y[COORD_WIDTH-1], i_pt_y} - {r_newer_y[COORD_WIDTH-1], r_newer_y};
    assign cent_dx = {i_pt_x[COORD_WIDTH-1], i_pt_x} - {r_older_x[COORD_WIDTH-1], r_older_x};
    assign cent_dy = {i_pt_y[COORD_WIDTH-1], i_pt_y} - {r_older_y[COORD_WIDTH-1], r_older_y};

    // Second point of a polyline has no older neighbor: forward difference
    assign first_dx = (r_points_seen == 2'd1) ? back_dx : cent_dx;
    assign first_dy = (r_points_seen == 2'd1) ? back_dy : cent_dy;

    // Hold input while the final point's second vector waits for the queue
    assign o_pt_ready = !r_pend && i_vec_ready;
    assign accept     = i_pt_valid && o_pt_ready;

    always_comb begin
        o_vec_valid = 1'b0;
        o_vec_data  = '0;
        if (r_pend) begin
            o_vec_valid = 1'b1;
            o_vec_data  = {r_pend_dx, r_pend_dy, 1'b1};
        end else if (accept && r_points_seen == 2'd0) begin
            // Lone point: a zero vector yields angle zero
            o_vec_valid = i_pt_last;
            o_vec_data  = {{DIFF_W{1'b0}}, {DIFF_W{1'b0}}, 1'b1};
        end else if (accept) begin
            o_vec_valid = 1'b1;
            o_vec_data  = {first_dx, first_dy, 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_points_seen <= 2'd0;
            r_pend        <= 1'b0;
            r_older_x     <= '0;
            r_older_y     <= '0;
            r_newer_x     <= '0;
            r_newer_y     <= '0;
        end else begin
            if (r_pend && i_vec_ready) begin
                r_pend <= 1'b0;
            end
            if (accept) begin
                r_newer_x <= i_pt_x;
                r_newer_y <= i_pt_y;
                if (r_points_seen == 2'd0) begin
                    r_points_seen <= i_pt_last ? 2'd0 : 2'd1;
                end else begin
                    r_older_x     <= r_newer_x;
                    r_older_y     <= r_newer_y;
                    r_points_seen <= i_pt_last ? 2'd0 : 2'd2;
                    r_pend        <= i_pt_last;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pend_dx <= back_dx;
            r_pend_dy <= back_dy;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/ptac_queue.sv -----
// ----------------------------------------------------------------------------
// ptac_queue
// Short FIFO of difference vectors between the window and the CORDIC.
// ----------------------------------------------------------------------------
`default_nettype none

module ptac_queue #(
    parameter int DATA_W = 67,
    parameter int DEPTH  = ptac_pkg::QUEUE_DEPTH,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push_valid,
    output logic                   o_push_ready,
    input  wire logic [DATA_W-1:0] i_push_data,
    output logic                   o_pop_valid,
    input  wire logic              i_pop_ready,
    output logic [DATA_W-1:0]      o_pop_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              push, pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= bump(r_wr_ptr);
            end
            if (pop) begin
                r_rd_ptr <= bump(r_rd_ptr);
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/ptac_back.sv -----
// ----------------------------------------------------------------------------
// ptac_back
// Iterative vectoring CORDIC, one micro-rotation per cycle, with output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ptac_back #(
    parameter int COORD_WIDTH   = ptac_pkg::COORD_WIDTH_DEF,
    parameter int ANGLE_WIDTH   = ptac_pkg::ANGLE_WIDTH_DEF,
    parameter int CORDIC_STAGES = ptac_pkg::CORDIC_STAGES_DEF,
    localparam int DIFF_W       = COORD_WIDTH + 1,
    localparam int VEC_W        = 2 * DIFF_W + 1,
    localparam int CW           = ptac_pkg::CORD_W,
    localparam int SHIFT        = ptac_pkg::SCALE_TOP - COORD_WIDTH,
    localparam int CNT_W        = $clog2(CORDIC_STAGES)
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_vec_valid,
    output logic                        o_vec_ready,
    input  wire logic [VEC_W-1:0]       i_vec_data,
    output logic                        o_res_valid,
    input  wire logic                   i_res_ready,
    output logic signed [ANGLE_WIDTH-1:0] o_res_angle,
    output logic                        o_res_last
);

    ptac_pkg::t_back_state r_state, n_state;

    logic signed [CW-1:0] r_x, r_y;
    logic [31:0]          r_z;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_zero, r_last;

    logic                          r_out_valid;
    logic signed [ANGLE_WIDTH-1:0] r_out_angle;
    logic                          r_out_last;

    logic                     pop, load_out, last_stage, out_free;
    logic signed [DIFF_W-1:0] q_dx, q_dy;
    logic                     q_last;
    logic signed [CW-1:0]     sx, sy, xs, ys;
    logic [31:0]              atan_i, z_round;

    assign q_dx   = i_vec_data[VEC_W-1 -: DIFF_W];
    assign q_dy   = i_vec_data[DIFF_W:1];
    assign q_last = i_vec_data[0];

    assign sx = {{(CW - DIFF_W){q_dx[DIFF_W-1]}}, q_dx} <<< SHIFT;
    assign sy = {{(CW - DIFF_W){q_dy[DIFF_W-1]}}, q_dy} <<< SHIFT;

    assign xs     = r_x >>> r_cnt;
    assign ys     = r_y >>> r_cnt;
    assign atan_i = ptac_pkg::atan_turn(ptac_pkg::ATAN_IDX_W'(r_cnt));

    assign last_stage = (r_cnt == CNT_W'(CORDIC_STAGES - 1));
    assign out_free   = !r_out_valid || i_res_ready;
    assign z_round    = r_z + (32'd1 << (31 - ANGLE_WIDTH));

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ptac_pkg::BK_IDLE: if (i_vec_valid) n_state = ptac_pkg::BK_RUN;
            ptac_pkg::BK_RUN:  if (last_stage)  n_state = ptac_pkg::BK_DONE;
            ptac_pkg::BK_DONE: if (out_free)    n_state = ptac_pkg::BK_IDLE;
            default:           n_state = ptac_pkg::BK_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        pop      = 1'b0;
        load_out = 1'b0;
        case (r_state)
            ptac_pkg::BK_IDLE: pop      = i_vec_valid;
            ptac_pkg::BK_DONE: load_out = out_free;
            default: begin
                pop      = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    assign o_vec_ready = (r_state == ptac_pkg::BK_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ptac_pkg::BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_cnt  <= '0;
            r_zero <= (q_dx == '0) && (q_dy == '0);
            r_last <= q_last;
            // Fold the left half-plane into the right by a quarter turn
            if (sx < 0) begin
                if (sy >= 0) begin
                    r_x <= sy;
                    r_y <= -sx;
                    r_z <= ptac_pkg::Z_POS_QUARTER;
                end else begin
                    r_x <= -sy;
                    r_y <= sx;
                    r_z <= ptac_pkg::Z_NEG_QUARTER;
                end
            end else begin
                r_x <= sx;
                r_y <= sy;
                r_z <= '0;
            end
        end else if (r_state == ptac_pkg::BK_RUN) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_y > 0) begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + atan_i;
            end else begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - atan_i;
            end
        end
        if (load_out) begin
            r_out_angle <= r_zero ? '0 : z_round[31 -: ANGLE_WIDTH];
            r_out_last  <= r_last;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res_angle = r_out_angle;
    assign o_res_last  = r_out_last;

endmodule

`default_nettype wire

// ----- rtl/core/polyline_tangent_angle_top.sv -----
// ----------------------------------------------------------------------------
// polyline_tangent_angle_top
// Tangent direction at each point of a 2-D polyline, as a binary angle.
// ----------------------------------------------------------------------------
//  port       dir   carries
//  i_point    in    x_coord, y_coord (signed Q16.16), last_point
//  o_result   out   angle (binary angle, signed), last_angle
//
//  A point is taken each cycle while the vector queue has room; a final
//  point holds the input until its second vector is queued. The CORDIC
//  takes a new vector only after the last angle has left for the output
//  register, which sets the sustained rate. Reset is synchronous, active
//  low, and empties the window, queue and output register. A stalled result
//  holds in the output register while the CORDIC takes the next vector.
// ----------------------------------------------------------------------------
`default_nettype none

module polyline_tangent_angle_top #(
    parameter int COORD_WIDTH   = ptac_pkg::COORD_WIDTH_DEF,
    parameter int ANGLE_WIDTH   = ptac_pkg::ANGLE_WIDTH_DEF,
    parameter int CORDIC_STAGES = ptac_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    ptac_point_if.sink    i_point,
    ptac_angle_if.source  o_result
);

    localparam int DIFF_W = COORD_WIDTH + 1;
    localparam int VEC_W  = 2 * DIFF_W + 1;

    logic             f_valid, f_ready, b_valid, b_ready;
    logic [VEC_W-1:0] f_data, b_data;

    ptac_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pt_valid  (i_point.valid),
        .o_pt_ready  (i_point.ready),
        .i_pt_x      (i_point.x_coord),
        .i_pt_y      (i_point.y_coord),
        .i_pt_last   (i_point.last_point),
        .o_vec_valid (f_valid),
        .i_vec_ready (f_ready),
        .o_vec_data  (f_data)
    );

    ptac_queue #(
        .DATA_W (VEC_W),
        .DEPTH  (ptac_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push_data  (f_data),
        .o_pop_valid  (b_valid),
        .i_pop_ready  (b_ready),
        .o_pop_data   (b_data)
    );

    ptac_back #(
        .COORD_WIDTH   (COORD_WIDTH),
        .ANGLE_WIDTH   (ANGLE_WIDTH),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vec_valid (b_valid),
        .o_vec_ready (b_ready),
        .i_vec_data  (b_data),
        .o_res_valid (o_result.valid),
        .i_res_ready (o_result.ready),
        .o_res_angle (o_result.angle),
        .o_res_last  (o_result.last_angle)
    );

endmodule

`default_nettype wire

// ----- tb/sv/polyline_tangent_angle_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// polyline_tangent_angle_top_test
// Self-checking bench for the polyline tangent angle block.
// A short table of hand-picked points, then random polylines in several
// coordinate styles, go through the point stream. A predictor of the window
// and the vectoring CORDIC supplies the expected angles, which are compared
// in order with every transfer on the result stream.
// ----------------------------------------------------------------------------

module polyline_tangent_angle_top_test;

    localparam int CW     = ptac_pkg::COORD_WIDTH_DEF;
    localparam int AW     = ptac_pkg::ANGLE_WIDTH_DEF;
    localparam int NSTAGE = ptac_pkg::CORDIC_STAGES_DEF;

    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam int                   ONE  = 65536;

    localparam logic [31:0] QUARTER_POS = 32'h4000_0000;
    localparam logic [31:0] QUARTER_NEG = 32'hC000_0000;

    // atan(2^-i) in 32-bit fractions of a turn, index 0 leftmost
    localparam logic [0:15][31:0] ATAN_TURNS = {
        32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
        32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
        32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
        32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D
    };

    localparam int IDLE_PCT  = 28;
    localparam int N_POINTS  = 1950;
    localparam int DRAIN_CAP = 200000;

    typedef struct packed {
        logic signed [CW-1:0] x_pt;
        logic signed [CW-1:0] y_pt;
        logic                 last_pt;
        logic                 typed;
        logic signed [AW-1:0] ang;
    } t_point_row;

    typedef struct packed {
        logic signed [AW-1:0] angle;
        logic                 last_angle;
    } t_angle_note;

    logic i_clk;
    logic i_rst_n;

    ptac_point_if #(.COORD_WIDTH(CW)) point_bus ();
    ptac_angle_if #(.ANGLE_WIDTH(AW)) angle_bus ();

    polyline_tangent_angle_top #(
        .COORD_WIDTH  (CW),
        .ANGLE_WIDTH  (AW),
        .CORDIC_STAGES(NSTAGE)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_point (point_bus),
        .o_result(angle_bus)
    );

    // sliding window of the predictor
    logic signed [CW-1:0] win_old_x, win_old_y, win_new_x, win_new_y;
    logic [1:0]           win_count;

    t_angle_note angles_due[$];
    t_point_row  opening_rows [22];

    bit steady_run;
    int points_sent;
    int polylines_done;
    int single_points;
    int angles_checked;
    int fail_count;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // direction of (dx, dy) as a binary angle, vectoring CORDIC
    function automatic logic signed [AW-1:0] heading(input longint dx, input longint dy);
        longint      x, y, xs, ys;
        logic [31:0] z;
        z = '0;
        if (dx == 0 && dy == 0)
            return '0;
        x = dx * (longint'(1) <<< (60 - CW));
        y = dy * (longint'(1) <<< (60 - CW));
        // fold the left half-plane into the right one
        if (x < 0) begin
            xs = x;
            if (y >= 0) begin
                x = y;
                y = -xs;
                z = QUARTER_POS;
            end else begin
                x = -y;
                y = xs;
                z = QUARTER_NEG;
            end
        end
        for (int i = 0; i < NSTAGE; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_TURNS[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_TURNS[i];
            end
        end
        z = z + (32'd1 << (31 - AW));
        return z[31 -: AW];
    endfunction

    function automatic logic signed [CW-1:0] extreme_coord();
        case ($urandom_range(5))
            0:       return CMIN;
            1:       return CMAX;
            2:       return '0;
            3:       return '1;
            4:       return 1;
            default: return $urandom();
        endcase
    endfunction

    // drive one point, wait for its transfer, then book the angles it releases
    task automatic send_point(input logic signed [CW-1:0] px, input logic signed [CW-1:0] py,
                              input logic fin, input logic typed,
                              input logic signed [AW-1:0] typed_ang);
        t_angle_note note;
        while (!steady_run && $urandom_range(99) < IDLE_PCT) begin
            @(negedge i_clk);
            point_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        point_bus.valid      <= 1'b1;
        point_bus.x_coord    <= px;
        point_bus.y_coord    <= py;
        point_bus.last_point <= fin;
        do @(posedge i_clk); while (point_bus.ready !== 1'b1);
        points_sent++;

        if (win_count == 2'd0) begin
            win_new_x = px;
            win_new_y = py;
            win_count = 2'd1;
            if (fin) begin
                note.angle      = '0;
                note.last_angle = 1'b1;
                angles_due = {angles_due, note};
                win_count = 2'd0;
                single_points++;
                polylines_done++;
            end
        end else begin
            // forward difference on the second point, central after that
            if (win_count == 2'd1)
                note.angle = heading(longint'(px) - longint'(win_new_x),
                                     longint'(py) - longint'(win_new_y));
            else
                note.angle = heading(longint'(px) - longint'(win_old_x),
                                     longint'(py) - longint'(win_old_y));
            if (typed)
                note.angle = typed_ang;
            note.last_angle = 1'b0;
            angles_due = {angles_due, note};
            win_old_x = win_new_x;
            win_old_y = win_new_y;
            win_new_x = px;
            win_new_y = py;
            win_count = 2'd2;
            if (fin) begin
                note.angle = typed ? typed_ang :
                             heading(longint'(px) - longint'(win_old_x),
                                     longint'(py) - longint'(win_old_y));
                note.last_angle = 1'b1;
                angles_due = {angles_due, note};
                win_count = 2'd0;
                polylines_done++;
            end
        end
    endtask

    // hold the point stream until every booked angle has come out
    task automatic drain_angles();
        int spins = 0;
        while (angles_due.size() != 0 && spins < DRAIN_CAP) begin
            @(negedge i_clk);
            point_bus.valid <= 1'b0;
            @(posedge i_clk);
            spins++;
        end
    endtask

    always @(negedge i_clk)
        angle_bus.ready <= steady_run || ($urandom_range(99) >= IDLE_PCT);

    always @(posedge i_clk) begin
        t_angle_note due;
        if (i_rst_n === 1'b1 && angle_bus.valid === 1'b1 && angle_bus.ready === 1'b1) begin
            angles_checked++;
            if (angles_due.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected angle %0d last_angle %0b", $time,
                         angle_bus.angle, angle_bus.last_angle);
            end else begin
                due = angles_due.pop_front();
                if (angle_bus.angle !== due.angle) begin
                    fail_count++;
                    $display("%0t: angle expected %0d, got %0d", $time,
                             due.angle, angle_bus.angle);
                end
                if (angle_bus.last_angle !== due.last_angle) begin
                    fail_count++;
                    $display("%0t: last_angle expected %0b, got %0b", $time,
                             due.last_angle, angle_bus.last_angle);
                end
            end
        end
    end

    initial begin
        int                   plen, mode, step, dir_x, dir_y;
        logic signed [CW-1:0] px, py;
        bit                   held_once;

        i_rst_n              = 1'b0;
        point_bus.valid      = 1'b0;
        point_bus.x_coord    = '0;
        point_bus.y_coord    = '0;
        point_bus.last_point = 1'b0;
        angle_bus.ready      = 1'b0;
        steady_run           = 1'b0;
        held_once            = 1'b0;
        win_old_x = '0; win_old_y = '0; win_new_x = '0; win_new_y = '0;
        win_count = '0;
        points_sent = 0; polylines_done = 0; single_points = 0;
        angles_checked = 0; fail_count = 0;

        //                x      y      last  typed ang
        opening_rows = '{
            '{32'sd5,    32'sd7,      1'b1, 1'b1, '0},  // one-point stream
            '{'0,        '0,          1'b0, 1'b0, '0},
            '{'0,        '0,          1'b0, 1'b1, '0},  // zero difference
            '{ONE,       '0,          1'b0, 1'b0, '0},
            '{ONE,       ONE,         1'b0, 1'b0, '0},
            '{'0,        ONE,         1'b0, 1'b0, '0},  // left half, y >= 0
            '{-ONE,      '0,          1'b0, 1'b0, '0},  // left half, y < 0
            '{-2 * ONE,  '0,          1'b1, 1'b0, '0},  // backward along -x
            '{CMIN,      CMIN,        1'b0, 1'b0, '0},
            '{CMAX,      CMAX,        1'b0, 1'b0, '0},
            '{CMIN,      CMAX,        1'b0, 1'b0, '0},
            '{CMAX,      CMIN,        1'b1, 1'b0, '0},
            '{CMAX,      '0,          1'b0, 1'b0, '0},  // two-point stream
            '{CMIN,      '0,          1'b1, 1'b0, '0},
            '{32'sd123,  -32'sd456,   1'b0, 1'b0, '0},
            '{32'sd123,  -32'sd456,   1'b1, 1'b1, '0},  // zero difference at the end
            '{CMIN,      CMAX,        1'b1, 1'b1, '0},
            '{'0,        '0,          1'b0, 1'b0, '0},  // one-lsb differences
            '{'0,        -32'sd1,     1'b0, 1'b0, '0},
            '{32'sd1,    -32'sd1,     1'b0, 1'b0, '0},
            '{32'sd1,    '0,          1'b1, 1'b0, '0},
            '{CMAX,      CMAX,        1'b1, 1'b1, '0}
        };

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (opening_rows[r])
            send_point(opening_rows[r].x_pt, opening_rows[r].y_pt, opening_rows[r].last_pt,
                       opening_rows[r].typed, opening_rows[r].ang);
        drain_angles();

        while (points_sent < N_POINTS) begin
            if (!held_once && points_sent >= 1300) begin
                drain_angles();
                held_once = 1'b1;
            end
            plen = $urandom_range(99);
            plen = (plen < 8)  ? 1 :
                   (plen < 20) ? 2 :
                   (plen < 23) ? $urandom_range(40, 80) : $urandom_range(3, 14);
            mode = $urandom_range(3);
            step = 1 << $urandom_range(0, 20);
            if (mode == 3) begin
                px = extreme_coord();
                py = extreme_coord();
            end else begin
                px = $urandom();
                py = $urandom();
            end
            for (int k = 0; k < plen; k++) begin
                if (k > 0) begin
                    case (mode)
                        0: begin
                            px = $urandom();
                            py = $urandom();
                        end
                        1: begin
                            // small random walk, about +/-16 in Q16.16
                            px = px + $signed(32'($urandom_range(0, 2097152))) - 32'sd1048576;
                            py = py + $signed(32'($urandom_range(0, 2097152))) - 32'sd1048576;
                        end
                        2: begin
                            // grid steps: axes, diagonals and repeated points
                            dir_x = int'($urandom_range(0, 2)) - 1;
                            dir_y = int'($urandom_range(0, 2)) - 1;
                            px = px + dir_x * step;
                            py = py + dir_y * step;
                        end
                        default: begin
                            px = extreme_coord();
                            py = extreme_coord();
                        end
                    endcase
                end
                steady_run = (points_sent >= 700 && points_sent < 1000);
                send_point(px, py, k == plen - 1, 1'b0, '0);
            end
        end
        steady_run = 1'b0;

        @(negedge i_clk);
        point_bus.valid <= 1'b0;
        drain_angles();
        repeat (4 * NSTAGE + 16) @(posedge i_clk);

        if (angles_due.size() != 0) begin
            fail_count++;
            $display("%0t: %0d expected angles never arrived", $time, angles_due.size());
        end
        $display("covered %0d points in %0d polylines (%0d single-point)",
                 points_sent, polylines_done, single_points);
        $display("checked %0d angles, %0d failures", angles_checked, fail_count);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
